[src/dq_pkg.sv]
package dq_pkg;

  // command codes carried in the command field
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_SEARCH     = 3'd3,
    CMD_CLEAR      = 3'd4
  } dq_cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SRCH,
    ST_RD,
    ST_DONE
  } dq_state_t;

  // input word
  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] data_value;
  } dq_in_t;

  // result word
  typedef struct packed {
    logic [31:0] front_value;
    logic        not_empty;
    logic        found;
    logic [4:0]  item_count;
    logic        error;
  } dq_out_t;

  // controls for the compare unit
  typedef struct packed {
    logic load;
    logic check;
  } dq_mctl_t;

endpackage

[src/dq_ram.sv]
module dq_ram import dq_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_BITS-1:0]     wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WORD_BITS-1:0]     rd_data
);

  logic [WORD_BITS-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

[src/dq_match.sv]
module dq_match import dq_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dq_mctl_t             ctl,
  input  logic [WORD_BITS-1:0] key,
  input  logic [WORD_BITS-1:0] rd_data,
  output logic                 found
);

  logic [WORD_BITS-1:0] key_r;
  logic                 found_r;
  logic                 found_nxt;

  // shared equality compare, sticky hit
  always_comb begin
    found_nxt = found_r;
    if (ctl.load) begin
      found_nxt = 1'b0;
    end else if (ctl.check && (rd_data == key_r)) begin
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  // search key
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= key;
    end
  end

  assign found = found_r;

endmodule

[src/double_ended_queue.sv]
// push, pop, clear and unused commands: EXEC, RD, DONE, then the registered result strobe
// search: EXEC, SRCH until a hit or all words are read, RD, DONE; one stored word compared per cycle
// through the single read port of the word memory and the shared compare unit
// busy drops in the result cycle; next word taken at its closing edge, none while busy
// reset (rst_n low, synchronous) empties the queue; the word memory is not cleared
// results are shown for one cycle on out_valid and cannot be stalled
module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dq_in_t  in_data,
  output logic    out_valid,
  output dq_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  dq_state_t            state_r, state_nxt;
  logic [2:0]           cmd_r, cmd_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        occ_r, occ_nxt;
  logic [CW-1:0]        issue_r, issue_nxt;
  logic                 chk_r, chk_nxt;
  logic                 err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  dq_out_t              out_r, out_nxt;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [63:0]          rd_wide;
  dq_mctl_t             mctl;
  logic                 match_found;
  logic                 full;
  logic                 empty;
  logic [AW-1:0]        head_dec;
  logic [AW-1:0]        back_slot;
  logic [AW-1:0]        srch_slot;
  logic [AW-1:0]        head_inc;

  // ring index add, base below the depth, offset up to the depth
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  assign full      = (occ_r == DEPTH_C);
  assign empty     = (occ_r == '0);
  assign head_dec  = (head_r == '0) ? LAST_SLOT : head_r - AW'(1);
  assign head_inc  = wrap_add(head_r, CW'(1));
  assign back_slot = wrap_add(head_r, occ_r);
  assign srch_slot = wrap_add(head_r, issue_r);
  assign rd_wide   = 64'(rd_data);

  dq_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (word_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dq_match #(
    .WORD_BITS (WORD_BITS)
  ) u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .key     (word_r),
    .rd_data (rd_data),
    .found   (match_found)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    word_nxt      = word_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    issue_nxt     = issue_r;
    chk_nxt       = chk_r;
    err_nxt       = err_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    rd_addr       = head_r;
    mctl          = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_data.command;
          word_nxt  = WORD_BITS'(in_data.data_value);
          err_nxt   = 1'b0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        mctl.load = 1'b1;
        state_nxt = ST_RD;
        case (cmd_r)
          CMD_PUSH_FRONT: begin
            if (full) begin
              err_nxt = 1'b1;
            end else begin
              head_nxt = head_dec;
              wr_en    = 1'b1;
              wr_addr  = head_dec;
              occ_nxt  = occ_r + CW'(1);
            end
          end
          CMD_PUSH_BACK: begin
            if (full) begin
              err_nxt = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_addr = back_slot;
              occ_nxt = occ_r + CW'(1);
            end
          end
          CMD_POP_FRONT: begin
            if (empty) begin
              err_nxt = 1'b1;
            end else begin
              head_nxt = head_inc;
              occ_nxt  = occ_r - CW'(1);
            end
          end
          CMD_SEARCH: begin
            issue_nxt = '0;
            chk_nxt   = 1'b0;
            state_nxt = ST_SRCH;
          end
          CMD_CLEAR: begin
            head_nxt = '0;
            occ_nxt  = '0;
          end
          default: begin
          end
        endcase
      end
      ST_SRCH: begin
        // one read issued and one word compared per cycle, until a hit or every stored word is read
        rd_addr    = srch_slot;
        mctl.check = chk_r;
        if ((issue_r != occ_r) && !match_found) begin
          issue_nxt = issue_r + CW'(1);
          chk_nxt   = 1'b1;
        end else begin
          chk_nxt = 1'b0;
        end
        if (match_found || ((issue_r == occ_r) && !chk_r)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        rd_addr   = head_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_nxt.front_value = empty ? 32'd0 : rd_wide[31:0];
        out_nxt.not_empty   = !empty;
        out_nxt.found       = match_found;
        out_nxt.item_count  = 5'(occ_r);
        out_nxt.error       = err_r;
        out_valid_nxt       = 1'b1;
        state_nxt           = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      issue_r     <= '0;
      chk_r       <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      issue_r     <= issue_nxt;
      chk_r       <= chk_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    word_r <= word_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/dq_chk.sv]
module dq_chk import dq_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    start,
  input logic    busy,
  input dq_in_t  in_data,
  input logic    out_valid,
  input dq_out_t out_data
);

  // an accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // a result only closes a busy stretch
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of an operation");

  // empty queue shows a zero front word
  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.not_empty) |-> (out_data.front_value == 32'd0))
    else $error("front word not zero on empty queue");

  // an error never comes with a search hit
  a_err_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |-> !out_data.found)
    else $error("error and found together");

endmodule

bind double_ended_queue dq_chk u_dq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
